>>> rtl/esc_pkg.sv
// esc_pkg: shared types and constants for the elevator scan controller
// used by esc_step and elevator_scan_controller; no dependencies

package esc_pkg;

	localparam int FLOOR_W = 4;
	localparam int FUNC_W  = 2;
	localparam int CNT_W   = 8;
	localparam int MOVE_W  = 2;

	// item kinds
	localparam logic [FUNC_W-1:0] FUNC_CALL = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DEST = 2'd2;

	// motion codes
	localparam logic [MOVE_W-1:0] MOVE_NONE = 2'd0;
	localparam logic [MOVE_W-1:0] MOVE_UP   = 2'd1;
	localparam logic [MOVE_W-1:0] MOVE_DOWN = 2'd2;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [FLOOR_W-1:0] floor_t;

	typedef struct packed {
		floor_t position;
		logic   going_up;
		floor_t upper_target;
		floor_t lower_target;
		logic   awaiting_dest;
	} car_state_t;

	typedef struct packed {
		floor_t              car_floor;
		logic                heading_up;
		logic [MOVE_W-1:0]   motion;
		count_t              boarded_count;
		logic                wants_destination;
		logic                bad_floor;
	} result_t;

endpackage

>>> rtl/esc_step.sv
// esc_step: next-state and result logic for one request of the scan controller
// depends on esc_pkg

module esc_step import esc_pkg::*; #(
	parameter int NUM_FLOORS = 9
) (
	input  logic [FUNC_W-1:0] func,
	input  floor_t            floor,
	input  car_state_t        cur,
	input  count_t            cnt_cur [NUM_FLOORS],
	output car_state_t        nxt,
	output count_t            cnt_nxt [NUM_FLOORS],
	output result_t           res
);

	localparam logic [FLOOR_W:0] NF    = (FLOOR_W+1)'(NUM_FLOORS);
	localparam floor_t           TOP_F = FLOOR_W'(NUM_FLOORS - 1);

	logic              floor_ok;
	logic              bad;
	logic [MOVE_W-1:0] move;
	count_t            boarded;

	assign floor_ok = {1'b0, floor} < NF;

	always_comb begin
		nxt     = cur;
		cnt_nxt = cnt_cur;
		bad     = 1'b0;
		move    = MOVE_NONE;
		boarded = '0;

		if (cur.awaiting_dest) begin
			if (func != FUNC_DEST || !floor_ok) begin
				bad = 1'b1;
			end else begin
				if (floor > cur.position && floor > cur.upper_target) nxt.upper_target = floor;
				if (floor < cur.position && floor < cur.lower_target) nxt.lower_target = floor;
				nxt.awaiting_dest = 1'b0;
			end
		end else begin
			case (func)
				FUNC_CALL: begin
					if (floor_ok) begin
						for (int i = 0; i < NUM_FLOORS; i++) begin
							if (floor == FLOOR_W'(i) && cnt_cur[i] != CNT_MAX)
								cnt_nxt[i] = cnt_cur[i] + 1'b1;
						end
						if (floor > cur.position && floor > cur.upper_target)
							nxt.upper_target = floor;
						if (floor < cur.position && floor < cur.lower_target)
							nxt.lower_target = floor;
					end else begin
						bad = 1'b1;
					end
				end
				FUNC_TICK: begin
					if (cur.going_up) begin
						if (cur.upper_target > cur.position) begin
							nxt.position = cur.position + 1'b1;
							move = MOVE_UP;
						end else if (cur.lower_target < cur.position) begin
							nxt.going_up     = 1'b0;
							nxt.upper_target = '0;
							nxt.position     = cur.position - 1'b1;
							move = MOVE_DOWN;
						end
					end else begin
						if (cur.lower_target < cur.position) begin
							nxt.position = cur.position - 1'b1;
							move = MOVE_DOWN;
						end else if (cur.upper_target > cur.position) begin
							nxt.going_up     = 1'b1;
							nxt.lower_target = TOP_F;
							nxt.position     = cur.position + 1'b1;
							move = MOVE_UP;
						end
					end
				end
				default: begin
					bad = 1'b1;
				end
			endcase

			// boarding at the floor the car now stands on
			for (int i = 0; i < NUM_FLOORS; i++) begin
				if (nxt.position == FLOOR_W'(i) && cnt_nxt[i] != '0) begin
					boarded           = cnt_nxt[i];
					cnt_nxt[i]        = '0;
					nxt.awaiting_dest = 1'b1;
				end
			end
		end
	end

	always_comb begin
		res.car_floor         = nxt.position;
		res.heading_up        = nxt.going_up;
		res.motion            = move;
		res.boarded_count     = boarded;
		res.wants_destination = nxt.awaiting_dest;
		res.bad_floor         = bad;
	end

endmodule

>>> rtl/elevator_scan_controller.sv
// elevator_scan_controller: single-car elevator controller, top level
// depends on esc_pkg and esc_step

// Takes one request per clock and gives one result per request. The path
// after acceptance is a request register, then the state update and the result
// register. The whole state (car position, direction, upper and lower targets,
// the per-floor waiting counters and the destination flag) updates in the
// same cycle the result is formed, so requests may follow back to back. The
// result register frees as soon as its result is taken, so the request side
// only stalls while a result is held by res_stall. Call requests count people
// waiting at a floor (saturating at 255) and widen the targets; travel ticks
// move the car one floor in SCAN order; boarding reports and clears the count
// at the car's floor and then only a destination request is expected.
// Reset puts the car at HOME_FLOOR (or the top floor if that is out of range),
// heading up, with all waiting counters clear.

module elevator_scan_controller import esc_pkg::*; #(
	parameter int NUM_FLOORS = 9,
	parameter int HOME_FLOOR = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [FLOOR_W-1:0] floor,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output logic [FLOOR_W-1:0] car_floor,
	output logic              heading_up,
	output logic [MOVE_W-1:0] motion,
	output logic [CNT_W-1:0]  boarded_count,
	output logic              wants_destination,
	output logic              bad_floor
);

	localparam int     START_I = (HOME_FLOOR < NUM_FLOORS) ? HOME_FLOOR : NUM_FLOORS - 1;
	localparam floor_t START_F = FLOOR_W'(START_I);
	localparam floor_t TOP_F   = FLOOR_W'(NUM_FLOORS - 1);

	// request register
	logic              valid_s1;
	logic [FUNC_W-1:0] func_s1;
	floor_t            floor_s1;

	// car state and waiting counters, one counter per floor
	car_state_t state_q;
	count_t     count_q [NUM_FLOORS];

	// result register
	logic    res_valid_q;
	result_t res_q;

	car_state_t state_nxt;
	count_t     count_nxt [NUM_FLOORS];
	result_t    res_nxt;
	logic       advance;

	// request moves into the result register when that is empty or draining
	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			func_s1  <= func;
			floor_s1 <= floor;
		end
	end

	esc_step #(
		.NUM_FLOORS (NUM_FLOORS)
	) u_step (
		.func    (func_s1),
		.floor   (floor_s1),
		.cur     (state_q),
		.cnt_cur (count_q),
		.nxt     (state_nxt),
		.cnt_nxt (count_nxt),
		.res     (res_nxt)
	);

	// state commits only when the request is actually handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.position      <= START_F;
			state_q.going_up      <= 1'b1;
			state_q.upper_target  <= '0;
			state_q.lower_target  <= TOP_F;
			state_q.awaiting_dest <= 1'b0;
			for (int i = 0; i < NUM_FLOORS; i++) count_q[i] <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res_nxt;
	end

	assign res_valid         = res_valid_q;
	assign car_floor         = res_q.car_floor;
	assign heading_up        = res_q.heading_up;
	assign motion            = res_q.motion;
	assign boarded_count     = res_q.boarded_count;
	assign wants_destination = res_q.wants_destination;
	assign bad_floor         = res_q.bad_floor;

	// car never leaves the shaft
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.position <= TOP_F)
		else $error("car position beyond top floor");

	// a move up is always taken while heading up, a move down while heading down
	a_move_dir: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !((res_q.motion == MOVE_UP && !res_q.heading_up) ||
		(res_q.motion == MOVE_DOWN && res_q.heading_up)))
		else $error("motion disagrees with heading");

	// boarding always leaves the block waiting for a destination
	a_board_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.boarded_count != '0) |-> res_q.wants_destination)
		else $error("boarding without destination wait");

	// a rejected request never moves the car
	a_bad_still: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.bad_floor) |-> res_q.motion == MOVE_NONE)
		else $error("car moved on a rejected request");

endmodule

>>> sim/tb_elevator_scan_controller.sv
// tb_elevator_scan_controller: self-checking testbench for the elevator scan controller
// depends on esc_pkg and elevator_scan_controller; predicts every result in-house
// and checks it against the block, with random idling on both channels

`timescale 1ns / 1ps

module tb_elevator_scan_controller;
	import esc_pkg::*;

	localparam int FLOORS      = 9;
	localparam int HOME        = 3;
	localparam int HOLD_CYCLES = 40;
	// item kind with no meaning, the package leaves it unnamed
	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] kind;
		floor_t            fl;
	} request_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [FUNC_W-1:0]   func = FUNC_CALL;
	logic [FLOOR_W-1:0]  floor = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic [FLOOR_W-1:0]  car_floor;
	logic                heading_up;
	logic [MOVE_W-1:0]   motion;
	logic [CNT_W-1:0]    boarded_count;
	logic                wants_destination;
	logic                bad_floor;

	// requests waiting to be offered, and results the car should give back
	request_t req_backlog[$];
	result_t  predicted_results[$];
	int       mismatches = 0;

	// idling control
	bit       calm = 1'b0;
	bit       hold_req = 1'b0;
	int       hold_left;
	int       gap_left;
	int       stall_left;

	// driver and monitor scratch
	result_t  drv_pred;
	request_t drv_next;
	result_t  mon_want;

	// car state as the testbench sees it
	floor_t   car_pos;
	logic     car_up;
	floor_t   up_tgt;
	floor_t   dn_tgt;
	count_t   waiting [FLOORS];
	logic     dest_pending;

	elevator_scan_controller #(
		.NUM_FLOORS(FLOORS),
		.HOME_FLOOR(HOME)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.floor(floor),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.car_floor(car_floor),
		.heading_up(heading_up),
		.motion(motion),
		.boarded_count(boarded_count),
		.wants_destination(wants_destination),
		.bad_floor(bad_floor)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// a call or a destination pushes the outer bound of the sweep
	task automatic widen_sweep(input floor_t fl);
		if (fl > car_pos && fl > up_tgt)
			up_tgt = fl;
		if (fl < car_pos && fl < dn_tgt)
			dn_tgt = fl;
	endtask

	// apply one request to the car state and form the result it causes
	task automatic advance_car(input logic [FUNC_W-1:0] kind, input floor_t fl,
			output result_t r);
		logic              fl_ok;
		logic [MOVE_W-1:0] mv;
		count_t            boarded;
		logic              bad;
		fl_ok   = fl < FLOORS;
		mv      = MOVE_NONE;
		boarded = '0;
		bad     = 1'b0;
		if (dest_pending) begin
			// only a valid destination gets the car going again
			if (kind != FUNC_DEST || !fl_ok) begin
				bad = 1'b1;
			end else begin
				widen_sweep(fl);
				dest_pending = 1'b0;
			end
		end else begin
			if (kind == FUNC_CALL) begin
				if (fl_ok) begin
					if (waiting[fl] != CNT_MAX)
						waiting[fl] = waiting[fl] + 1'b1;
					widen_sweep(fl);
				end else begin
					bad = 1'b1;
				end
			end else if (kind == FUNC_TICK) begin
				// keep heading while work lies ahead, else turn around
				if (car_up) begin
					if (up_tgt > car_pos) begin
						car_pos = car_pos + 1'b1;
						mv      = MOVE_UP;
					end else if (dn_tgt < car_pos) begin
						car_up  = 1'b0;
						up_tgt  = '0;
						car_pos = car_pos - 1'b1;
						mv      = MOVE_DOWN;
					end
				end else begin
					if (dn_tgt < car_pos) begin
						car_pos = car_pos - 1'b1;
						mv      = MOVE_DOWN;
					end else if (up_tgt > car_pos) begin
						car_up  = 1'b1;
						dn_tgt  = floor_t'(FLOORS - 1);
						car_pos = car_pos + 1'b1;
						mv      = MOVE_UP;
					end
				end
			end else begin
				bad = 1'b1;
			end
			// anyone waiting where the car now stands gets in
			if (waiting[car_pos] != '0) begin
				boarded               = waiting[car_pos];
				waiting[car_pos]      = '0;
				dest_pending          = 1'b1;
			end
		end
		r.car_floor         = car_pos;
		r.heading_up        = car_up;
		r.motion            = mv;
		r.boarded_count     = boarded;
		r.wants_destination = dest_pending;
		r.bad_floor         = bad;
	endtask

	// mostly plausible traffic with some junk mixed in
	function automatic request_t random_request();
		request_t q;
		int       pick;
		pick = $urandom_range(0, 99);
		q.fl = floor_t'($urandom_range(0, FLOORS - 1));
		if (pick < 30) begin
			q.kind = FUNC_CALL;
		end else if (pick < 68) begin
			q.kind = FUNC_TICK;
			q.fl   = floor_t'($urandom_range(0, 15));
		end else if (pick < 92) begin
			q.kind = FUNC_DEST;
		end else if (pick < 96) begin
			q.kind = FUNC_NONE;
			q.fl   = floor_t'($urandom_range(0, 15));
		end else begin
			// call or destination to a floor that does not exist
			q.kind = $urandom_range(0, 1) ? FUNC_CALL : FUNC_DEST;
			q.fl   = floor_t'($urandom_range(FLOORS, 15));
		end
		return q;
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// wait until every request is in and every result has come back
	task automatic wait_idle();
		while (req_backlog.size() != 0 || req_valid || predicted_results.size() != 0)
			@(posedge clk);
	endtask

	// request driver: predicts on acceptance, then offers the next request or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			func      <= FUNC_CALL;
			floor     <= '0;
			gap_left  <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				advance_car(func, floor, drv_pred);
				predicted_results.push_back(drv_pred);
			end
			if (!req_valid || !req_stall) begin
				if (gap_left != 0) begin
					gap_left  <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (req_backlog.size() == 0) begin
					req_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 4) == 0) begin
					// idle burst of random length
					gap_left  <= $urandom_range(0, 3);
					req_valid <= 1'b0;
				end else begin
					drv_next  = req_backlog.pop_front();
					req_valid <= 1'b1;
					func      <= drv_next.kind;
					floor     <= drv_next.fl;
				end
			end
		end
	end

	// long receiver hold-off, counted here on its own
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_req)
			hold_left <= HOLD_CYCLES;
	end

	// result stall: long hold-off first, then short random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall  <= 1'b0;
			stall_left <= 0;
		end else if (hold_left != 0) begin
			res_stall <= 1'b1;
		end else if (stall_left != 0) begin
			res_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			res_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 3);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// result monitor: every accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (predicted_results.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual car_floor %0d",
					$time, car_floor);
				mismatches++;
			end else begin
				mon_want = predicted_results.pop_front();
				check_field("car_floor", mon_want.car_floor, car_floor);
				check_field("heading_up", mon_want.heading_up, heading_up);
				check_field("motion", mon_want.motion, motion);
				check_field("boarded_count", mon_want.boarded_count, boarded_count);
				check_field("wants_destination", mon_want.wants_destination,
					wants_destination);
				check_field("bad_floor", mon_want.bad_floor, bad_floor);
			end
		end
	end

	initial begin
		floor_t   sat_floor;
		int       guard;

		// car starts at home, heading up, nobody waiting
		car_pos      = floor_t'(HOME);
		car_up       = 1'b1;
		up_tgt       = '0;
		dn_tgt       = floor_t'(FLOORS - 1);
		dest_pending = 1'b0;
		for (int i = 0; i < FLOORS; i++)
			waiting[i] = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle tick, junk, boarding at own floor, misuse while boarding
		req_backlog.push_back('{FUNC_TICK, 4'd15});
		req_backlog.push_back('{FUNC_CALL, 4'd15});
		req_backlog.push_back('{FUNC_NONE, 4'd0});
		req_backlog.push_back('{FUNC_DEST, 4'd5});
		req_backlog.push_back('{FUNC_CALL, 4'd3});
		req_backlog.push_back('{FUNC_CALL, 4'd5});
		req_backlog.push_back('{FUNC_TICK, 4'd0});
		req_backlog.push_back('{FUNC_NONE, 4'd15});
		req_backlog.push_back('{FUNC_DEST, 4'd12});
		req_backlog.push_back('{FUNC_DEST, 4'd3});
		// calls at both ends, ride to the top, turn around at the top
		req_backlog.push_back('{FUNC_CALL, 4'd8});
		req_backlog.push_back('{FUNC_CALL, 4'd0});
		repeat (5) req_backlog.push_back('{FUNC_TICK, 4'd7});
		req_backlog.push_back('{FUNC_DEST, 4'd0});
		repeat (8) req_backlog.push_back('{FUNC_TICK, 4'd8});
		req_backlog.push_back('{FUNC_DEST, 4'd8});
		req_backlog.push_back('{FUNC_TICK, 4'd1});
		wait_idle();

		// saturation: pile callers on one floor away from the car
		if (dest_pending) begin
			req_backlog.push_back('{FUNC_DEST, floor_t'(HOME)});
			wait_idle();
		end
		sat_floor = floor_t'((car_pos + 4) % FLOORS);
		repeat (258) req_backlog.push_back('{FUNC_CALL, sat_floor});
		wait_idle();
		// drive the car there one request at a time, serving any other stop
		guard = 0;
		while (waiting[sat_floor] != '0 && guard < 64) begin
			if (dest_pending)
				req_backlog.push_back('{FUNC_DEST, floor_t'($urandom_range(0, FLOORS - 1))});
			else
				req_backlog.push_back('{FUNC_TICK, floor_t'($urandom_range(0, 15))});
			wait_idle();
			guard++;
		end
		req_backlog.push_back('{FUNC_DEST, floor_t'($urandom_range(0, FLOORS - 1))});
		wait_idle();

		// random traffic while the receiver holds off, so the block backs up
		repeat (50) req_backlog.push_back(random_request());
		hold_req = 1'b1;
		while (hold_left == 0)
			@(posedge clk);
		hold_req = 1'b0;
		// sender pauses here until every result is back
		wait_idle();

		repeat (30) req_backlog.push_back(random_request());
		wait_idle();

		// closing stretch with no idling on either side
		calm = 1'b1;
		repeat (30) req_backlog.push_back(random_request());
		wait_idle();
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("PASS elevator_scan_controller");
		else
			$display("FAIL elevator_scan_controller");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAIL elevator_scan_controller");
		$finish;
	end

endmodule
